>>> src/video_memory_map_mirroring_macros.svh
// assertion macros for the video memory map block
// no dependencies; taken in by the modules that carry assertions
`ifndef VIDEO_MEMORY_MAP_MIRRORING_MACROS_SVH
`define VIDEO_MEMORY_MAP_MIRRORING_MACROS_SVH

`ifndef ASSERT_OFF
`define VMM_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define VMM_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define VMM_ASSERT(lbl, clk, rst, prop, msg)
`define VMM_NEVER(lbl, clk, rst, cond, msg)
`endif

`endif

>>> src/vmm_pkg.sv
// shared types and constants for the video memory map block
// no dependencies
package vmm_pkg;

   localparam int NAME_TABLE_BYTES = 2048;
   localparam int PALETTE_BYTES    = 32;

   localparam logic CMD_READ  = 1'b0;
   localparam logic CMD_WRITE = 1'b1;

   localparam logic [5:0] PALETTE_PAGE = 6'h3F;

   typedef struct packed {
      logic        cmd;
      logic [15:0] address;
      logic [7:0]  write_data;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       pattern_access;
   } rsp_type;

   typedef enum logic [1:0] {
      REGION_PATTERN,
      REGION_TABLE,
      REGION_PALETTE
   } region_type;

   typedef struct packed {
      region_type region;
      logic       is_write;
   } access_type;

   typedef enum logic {
      ST_CLEAR,
      ST_RUN
   } state_type;

endpackage

>>> src/vmm_ram.sv
// generic single-port ram with registered read
// no dependencies
module vmm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> src/vmm_decode.sv
// address fold, region decode and mirroring for the video bus
// depends on vmm_pkg
module vmm_decode #(
   parameter int NAME_TABLE_BYTES = vmm_pkg::NAME_TABLE_BYTES,
   parameter int PALETTE_BYTES    = vmm_pkg::PALETTE_BYTES
) (
   input  logic                                cmd,
   input  logic [15:0]                         address,
   input  logic                                pair_mode,
   output vmm_pkg::access_type                 acc,
   output logic [$clog2(NAME_TABLE_BYTES)-1:0] nt_idx,
   output logic [$clog2(PALETTE_BYTES)-1:0]    pal_idx
);

   localparam int NT_AW  = $clog2(NAME_TABLE_BYTES);
   localparam int PAL_AW = $clog2(PALETTE_BYTES);

   logic [13:0] folded;
   logic [1:0]  logical;
   logic        page;
   logic [4:0]  pal_raw;

   always_comb begin
      folded  = address[13:0];
      logical = folded[11:10];
      page    = pair_mode ? logical[1] : logical[0];
      nt_idx  = NT_AW'({page, folded[9:0]});
      pal_raw = folded[4:0];
      // sprite color zero entries mirror the background color zero entries
      if (pal_raw[4] && pal_raw[1:0] == 2'b00) begin
         pal_raw[4] = 1'b0;
      end
      pal_idx = PAL_AW'(pal_raw);

      acc.is_write = (cmd == vmm_pkg::CMD_WRITE);
      if (!folded[13]) begin
         acc.region = vmm_pkg::REGION_PATTERN;
      end else if (folded[13:8] == vmm_pkg::PALETTE_PAGE) begin
         acc.region = vmm_pkg::REGION_PALETTE;
      end else begin
         acc.region = vmm_pkg::REGION_TABLE;
      end
   end

endmodule

>>> src/video_memory_map_mirroring.sv
// top level of the video memory map block: decode, name-table and palette rams
// depends on vmm_pkg, vmm_decode, vmm_ram and the macros header
//
//   channel   direction   handshake           payload
//   req       in          req_valid/stall     vmm_pkg::req_type
//   rsp       out         rsp_valid/stall     vmm_pkg::rsp_type
//   csr       in          csr_we              pair_mode bit
//
// an accepted transfer reaches the ram in its accept cycle; the ram read register
// feeds the result register, and no new request is taken while one is pending
// after reset a clearing pass zeroes both rams over all NAME_TABLE_BYTES addresses
// with req held stalled; csr writes are taken throughout
// a stalled result holds the next request off until it is taken
`include "video_memory_map_mirroring_macros.svh"

module video_memory_map_mirroring #(
   parameter int NAME_TABLE_BYTES = vmm_pkg::NAME_TABLE_BYTES,
   parameter int PALETTE_BYTES    = vmm_pkg::PALETTE_BYTES
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  vmm_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output vmm_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic             csr_wdata
);

   localparam int NT_AW  = $clog2(NAME_TABLE_BYTES);
   localparam int PAL_AW = $clog2(PALETTE_BYTES);

   vmm_pkg::state_type  state_ff, state_in;
   logic [NT_AW-1:0]    clr_cnt_ff, clr_cnt_in;
   logic                pend_ff;
   vmm_pkg::access_type kind_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   vmm_pkg::rsp_type    rsp_data_ff, rsp_data_in;
   logic                pair_mode_ff;

   vmm_pkg::access_type acc;
   logic [NT_AW-1:0]    nt_idx;
   logic [PAL_AW-1:0]   pal_idx;
   logic                accept;
   logic                clearing;
   logic                pattern_data;

   logic                nt_we, nt_re, pal_we, pal_re;
   logic [NT_AW-1:0]    nt_addr;
   logic [PAL_AW-1:0]   pal_addr;
   logic [7:0]          nt_wdata, pal_wdata, nt_rdata, pal_rdata;

   vmm_decode #(
      .NAME_TABLE_BYTES(NAME_TABLE_BYTES),
      .PALETTE_BYTES(PALETTE_BYTES)
   ) u_decode (
      .cmd(req_data.cmd),
      .address(req_data.address),
      .pair_mode(pair_mode_ff),
      .acc(acc),
      .nt_idx(nt_idx),
      .pal_idx(pal_idx)
   );

   vmm_ram #(.WIDTH(8), .DEPTH(NAME_TABLE_BYTES)) u_nt_ram (
      .clock(clock),
      .we(nt_we),
      .re(nt_re),
      .addr(nt_addr),
      .wdata(nt_wdata),
      .rdata(nt_rdata)
   );

   vmm_ram #(.WIDTH(8), .DEPTH(PALETTE_BYTES)) u_pal_ram (
      .clock(clock),
      .we(pal_we),
      .re(pal_re),
      .addr(pal_addr),
      .wdata(pal_wdata),
      .rdata(pal_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= vmm_pkg::ST_CLEAR;
         clr_cnt_ff   <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pair_mode_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         pend_ff      <= accept;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            pair_mode_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff <= acc;
      end
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      state_in   = state_ff;
      clr_cnt_in = clr_cnt_ff;
      clearing   = 1'b0;
      case (state_ff)
         vmm_pkg::ST_CLEAR: begin
            clearing   = 1'b1;
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == NT_AW'(NAME_TABLE_BYTES - 1)) begin
               state_in = vmm_pkg::ST_RUN;
            end
         end
         vmm_pkg::ST_RUN: begin
            clearing = 1'b0;
         end
         default: begin
            state_in = vmm_pkg::ST_CLEAR;
         end
      endcase
   end

   assign req_stall = clearing || pend_ff || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      nt_we     = clearing || (accept && acc.region == vmm_pkg::REGION_TABLE && acc.is_write);
      nt_re     = accept && acc.region == vmm_pkg::REGION_TABLE && !acc.is_write;
      nt_addr   = clearing ? clr_cnt_ff : nt_idx;
      nt_wdata  = clearing ? 8'h00 : req_data.write_data;
      pal_we    = clearing ||
                  (accept && acc.region == vmm_pkg::REGION_PALETTE && acc.is_write);
      pal_re    = accept && acc.region == vmm_pkg::REGION_PALETTE && !acc.is_write;
      pal_addr  = clearing ? clr_cnt_ff[PAL_AW-1:0] : pal_idx;
      pal_wdata = clearing ? 8'h00 : req_data.write_data;
   end

   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (pend_ff) begin
         rsp_valid_in                = 1'b1;
         rsp_data_in.read_data       = 8'h00;
         rsp_data_in.pattern_access  = 1'b0;
         case (kind_ff.region)
            vmm_pkg::REGION_PATTERN: begin
               rsp_data_in.pattern_access = !kind_ff.is_write;
            end
            vmm_pkg::REGION_TABLE: begin
               rsp_data_in.read_data = kind_ff.is_write ? 8'h00 : nt_rdata;
            end
            vmm_pkg::REGION_PALETTE: begin
               rsp_data_in.read_data = kind_ff.is_write ? 8'h00 : pal_rdata;
            end
            default: begin
               rsp_data_in.read_data = 8'h00;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign pattern_data = rsp_data.pattern_access && (rsp_data.read_data != 8'h00);

   `VMM_ASSERT(a_accept_pends, clock, reset, accept |=> pend_ff, "accept without ram cycle")
   `VMM_NEVER(a_capture_free, clock, reset, pend_ff && rsp_valid_ff && rsp_stall, "result lost")
   `VMM_NEVER(a_no_rsp_clear, clock, reset, rsp_valid && clearing, "result during clearing")
   `VMM_NEVER(a_pattern_zero, clock, reset, rsp_valid && pattern_data, "pattern read with data")

endmodule
